[rtl/utb_pkg.sv]
package utb_pkg;

  // Table geometry and number formats
  localparam int USER_SLOTS      = 16;
  localparam int TOKEN_FRAC_BITS = 8;
  localparam int SLOT_AW         = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int CAP_W           = 8;
  localparam int RATE_W          = 16;
  localparam int TIME_W          = 32;
  localparam int TOK_W           = CAP_W + TOKEN_FRAC_BITS;
  localparam int PROD_W          = TIME_W + RATE_W;

  // Input request kinds
  localparam logic [1:0] RQ_TICK     = 2'd0;
  localparam logic [1:0] RQ_REGISTER = 2'd1;
  localparam logic [1:0] RQ_REQUEST  = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_GRANTED    = 3'd0;
  localparam logic [2:0] STAT_DENIED     = 3'd1;
  localparam logic [2:0] STAT_NOT_REG    = 3'd2;
  localparam logic [2:0] STAT_REGISTERED = 3'd3;
  localparam logic [2:0] STAT_ALREADY    = 3'd4;

  // One slot entry in the bucket table
  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [RATE_W-1:0] rate;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] last_time;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;     // latch accepted item, start table read
    logic tick;        // advance seconds counter
    logic do_reg;      // write a fresh entry, set valid bit
    logic do_mul;      // elapsed * rate into product register
    logic do_upd;      // write refilled bucket back
    logic load_early;  // result straight from the table read
    logic load_upd;    // result from the refill path
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_reg;      // held item is a registration
    logic in_range;    // slot index inside the table
    logic hit;         // slot in range and registered
  } sts_t;

endpackage

[rtl/utb_ram.sv]
module utb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/utb_ctrl.sv]
module utb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_req_type,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  utb_pkg::sts_t sts,
  output utb_pkg::cmd_t cmd
);
  import utb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            RQ_TICK: begin
              cmd.tick = 1'b1;
            end
            RQ_REGISTER, RQ_REQUEST: begin
              cmd.capture = 1'b1;
              state_nxt   = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (sts.is_reg) begin
          if (out_free) begin
            cmd.load_early = 1'b1;
            cmd.do_reg     = sts.in_range && !sts.hit;
            state_nxt      = S_IDLE;
          end
        end else if (sts.hit) begin
          cmd.do_mul = 1'b1;
          state_nxt  = S_UPD;
        end else if (out_free) begin
          cmd.load_early = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_UPD: begin
        if (out_free) begin
          cmd.do_upd   = 1'b1;
          cmd.load_upd = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_early || cmd.load_upd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/utb_dp.sv]
module utb_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    in_req_type,
  input  logic [3:0]    in_user_index,
  input  logic [7:0]    in_capacity,
  input  logic [15:0]   in_refill_rate,
  output logic [2:0]    out_status,
  output logic [15:0]   out_tokens_left,
  input  utb_pkg::cmd_t cmd,
  output utb_pkg::sts_t sts
);
  import utb_pkg::*;

  logic [3:0]            idx_r;
  logic                  is_reg_r;
  logic [CAP_W-1:0]      cap_r;
  logic [RATE_W-1:0]     rate_r;
  logic [TIME_W-1:0]     seconds_r;
  logic [USER_SLOTS-1:0] valid_r;
  logic [PROD_W-1:0]     prod_r;
  logic [2:0]            status_r;
  logic [15:0]           tokens_r;

  logic [SLOT_AW-1:0]    slot_a;
  logic [SLOT_AW-1:0]    ram_addr;
  logic                  in_range;
  logic                  hit;
  entry_t                rd_q;
  entry_t                wr_d;
  logic [TIME_W-1:0]     elapsed;
  logic [TOK_W-1:0]      cap_q;
  logic [TOK_W-1:0]      prod_sat;
  logic [TOK_W:0]        sum;
  logic [TOK_W-1:0]      level;
  logic                  grant;
  logic [TOK_W-1:0]      level_left;
  logic [2:0]            early_status;
  logic [15:0]           early_tokens;

  localparam logic [TOK_W-1:0] ONE_TOKEN = TOK_W'(1) << TOKEN_FRAC_BITS;

  assign slot_a   = SLOT_AW'(idx_r);
  assign ram_addr = cmd.capture ? SLOT_AW'(in_user_index) : slot_a;
  assign in_range = (32'(idx_r) < 32'(USER_SLOTS));
  assign hit      = in_range && valid_r[slot_a];

  assign sts.is_reg   = is_reg_r;
  assign sts.in_range = in_range;
  assign sts.hit      = hit;

  // Refill: saturate product first, then the sum, at capacity
  assign elapsed  = seconds_r - rd_q.last_time;
  assign cap_q    = TOK_W'(rd_q.capacity) << TOKEN_FRAC_BITS;
  assign prod_sat = (prod_r > PROD_W'(cap_q)) ? cap_q : TOK_W'(prod_r);
  assign sum      = {1'b0, rd_q.tokens} + {1'b0, prod_sat};
  assign level    = (sum > {1'b0, cap_q}) ? cap_q : sum[TOK_W-1:0];
  assign grant    = (level >= ONE_TOKEN);
  assign level_left = grant ? (level - ONE_TOKEN) : level;

  always_comb begin
    if (cmd.do_reg) begin
      wr_d.capacity  = cap_r;
      wr_d.rate      = rate_r;
      wr_d.tokens    = '0;
      wr_d.last_time = seconds_r;
    end else begin
      wr_d.capacity  = rd_q.capacity;
      wr_d.rate      = rd_q.rate;
      wr_d.tokens    = level_left;
      wr_d.last_time = seconds_r;
    end
  end

  always_comb begin
    early_status = STAT_NOT_REG;
    early_tokens = '0;
    if (is_reg_r && in_range) begin
      if (hit) begin
        early_status = STAT_ALREADY;
        early_tokens = 16'(rd_q.tokens);
      end else begin
        early_status = STAT_REGISTERED;
      end
    end
  end

  utb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (USER_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.do_reg || cmd.do_upd),
    .re    (cmd.capture),
    .addr  (ram_addr),
    .wdata (wr_d),
    .rdata (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r <= '0;
      valid_r   <= '0;
    end else begin
      if (cmd.tick) begin
        seconds_r <= seconds_r + TIME_W'(1);
      end
      if (cmd.do_reg) begin
        valid_r[slot_a] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r    <= in_user_index;
      is_reg_r <= (in_req_type == RQ_REGISTER);
      cap_r    <= in_capacity;
      rate_r   <= in_refill_rate;
    end
    if (cmd.do_mul) begin
      prod_r <= PROD_W'(elapsed) * PROD_W'(rd_q.rate);
    end
    if (cmd.load_early) begin
      status_r <= early_status;
      tokens_r <= early_tokens;
    end else if (cmd.load_upd) begin
      status_r <= grant ? STAT_GRANTED : STAT_DENIED;
      tokens_r <= 16'(level_left);
    end
  end

  assign out_status      = status_r;
  assign out_tokens_left = tokens_r;

endmodule

[rtl/per_user_token_bucket_limiter.sv]
// Per-user token bucket limiter. A table of 16 buckets (capacity in whole tokens, refill rate
// and token count in unsigned Q8.8, last-refill time) sits in a registered-read RAM, with one
// valid flop per slot cleared at reset; a 32-bit seconds counter advances on each tick item.
// Ticks give no result. A registration reads the table, then writes the fresh entry or gives
// an "already registered" answer. An access request to a live slot reads the table, then
// puts elapsed-seconds times rate into a product register, then saturates at capacity,
// takes one token if a whole one is present and writes the entry back.
// A request to an unregistered slot answers straight from the table read. The table's
// single read/write port and the multiply register set these steps; one item is in work at
// a time. A finished result sits in an output register, so the next item is taken while it
// waits; that item then holds in its last state until the waiting result is taken.
// Out-of-range slots, and requests to unregistered slots, answer status 2 with zero
// tokens; req_type 3 is dropped, like a tick.
module per_user_token_bucket_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_user_index,
  input  logic [7:0]  in_capacity,
  input  logic [15:0] in_refill_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_tokens_left
);
  import utb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle / table read / refill update
  utb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .sts         (sts),
    .cmd         (cmd)
  );

  // table, seconds counter, refill arithmetic, result register
  utb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_user_index   (in_user_index),
    .in_capacity     (in_capacity),
    .in_refill_rate  (in_refill_rate),
    .out_status      (out_status),
    .out_tokens_left (out_tokens_left),
    .cmd             (cmd),
    .sts             (sts)
  );

`ifndef SYNTHESIS
  // a live slot is never overwritten by a registration
  a_no_reg_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_reg |-> (sts.in_range && !sts.hit))
    else $error("registration write on a live or out-of-range slot");

  // refill write-back only for a registered slot
  a_upd_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_upd |-> sts.hit)
    else $error("bucket update on an unregistered slot");

  // a register/request transfer blocks input for at least the next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == RQ_REGISTER || in_req_type == RQ_REQUEST))
    |=> !in_ready)
    else $error("input ready while an item is in work");

  // a tick never loads a result
  a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |-> !(cmd.load_early || cmd.load_upd))
    else $error("tick produced a result");
`endif

endmodule
